// ----- hdl/thick_bresenham_line_stepper_top_assert.svh -----
// Assertion macros shared by the checker of the line stepper.
// Each takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef THICK_BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH
`define THICK_BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define TBLS_ASSERT_SAME(label, clk, rstn, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (conseq)) \
        else $error("line stepper check failed in the same cycle");

// The consequence must hold in the cycle after the condition.
`define TBLS_ASSERT_NEXT(label, clk, rstn, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (conseq)) \
        else $error("line stepper check failed in the following cycle");

`endif

// ----- hdl/tbls_pkg.sv -----
`default_nettype none

package tbls_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 24;
    localparam int BRUSH_PIXELS   = 9;
    localparam int IDX_W          = 4;
    localparam logic [IDX_W-1:0] BRUSH_LAST = IDX_W'(BRUSH_PIXELS - 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Request from the line core to the brush emitter.
    typedef struct packed {
        logic load;   // take a new point snapshot
        logic done;   // the point is the line endpoint
    } brush_ctl_t;

    // Brush offsets in emission order, as 2-bit signed values.
    function automatic logic signed [1:0] brush_dx(input logic [IDX_W-1:0] idx);
        logic signed [1:0] off;
        unique case (idx)
            4'd0:    off = 2'sd0;
            4'd1:    off = -2'sd1;
            4'd2:    off = 2'sd1;
            4'd3:    off = -2'sd1;
            4'd4:    off = 2'sd0;
            4'd5:    off = 2'sd1;
            4'd6:    off = 2'sd0;
            4'd7:    off = 2'sd1;
            4'd8:    off = -2'sd1;
            default: off = 2'sd0;
        endcase
        return off;
    endfunction

    function automatic logic signed [1:0] brush_dy(input logic [IDX_W-1:0] idx);
        logic signed [1:0] off;
        unique case (idx)
            4'd0, 4'd1, 4'd2: off = 2'sd0;
            4'd3, 4'd4, 4'd5: off = 2'sd1;
            4'd6, 4'd7, 4'd8: off = -2'sd1;
            default:          off = 2'sd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tbls_line_core.sv -----
`default_nettype none

module tbls_line_core #(
    parameter int COORD_BITS = tbls_pkg::COORD_BITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire                            in_op,
    input  wire  [COORD_BITS-1:0]          in_start_x,
    input  wire  [COORD_BITS-1:0]          in_start_y,
    input  wire  [COORD_BITS-1:0]          in_end_x,
    input  wire  [COORD_BITS-1:0]          in_end_y,
    input  wire  [tbls_pkg::COLOR_BITS-1:0] in_color,
    input  wire                            emit_free,
    output tbls_pkg::brush_ctl_t           ctl,
    output logic [COORD_BITS-1:0]          pt_x,
    output logic [COORD_BITS-1:0]          pt_y,
    output logic [tbls_pkg::COLOR_BITS-1:0] pt_color
);
    import tbls_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int ERR_W = CB + 2;

    // Input holding register.
    logic                  in_valid_reg, in_valid_next;
    logic                  in_op_reg;
    logic [CB-1:0]         in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;
    logic [COLOR_BITS-1:0] in_color_reg;

    // Line state.
    logic [CB-1:0]           cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CB-1:0]           tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic [DW-1:0]           dx_reg, dx_next, dy_reg, dy_next;
    logic                    neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [COLOR_BITS-1:0]   color_reg, color_next;
    logic                    active_reg, active_next;

    logic                    consume, do_start, do_step, done;
    logic signed [DW-1:0]    diff_x, diff_y;
    logic [DW-1:0]           abs_x, abs_y;
    logic signed [ERR_W-1:0] dx_s, dy_s, err_mx, err_my;
    logic                    move_x, move_y;

    assign do_start = in_valid_reg && (in_op_reg == OP_START);
    assign do_step  = in_valid_reg && (in_op_reg == OP_STEP) && active_reg && emit_free;
    assign consume  = do_start || do_step
                   || (in_valid_reg && (in_op_reg == OP_STEP) && !active_reg);
    assign in_ready = aresetn && (!in_valid_reg || consume);

    assign done = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);

    assign ctl.load = do_step;
    assign ctl.done = done;
    assign pt_x     = cur_x_reg;
    assign pt_y     = cur_y_reg;
    assign pt_color = color_reg;

    always_comb begin
        diff_x = $signed({in_ex_reg[CB-1], in_ex_reg}) - $signed({in_sx_reg[CB-1], in_sx_reg});
        diff_y = $signed({in_ey_reg[CB-1], in_ey_reg}) - $signed({in_sy_reg[CB-1], in_sy_reg});
        abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
        abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

        dx_s   = $signed({1'b0, dx_reg});
        dy_s   = $signed({1'b0, dy_reg});
        move_x = err_reg > -dx_s;
        move_y = err_reg < dy_s;
        err_mx = move_x ? dy_s : '0;
        err_my = move_y ? dx_s : '0;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (consume) begin
            in_valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            in_valid_next = 1'b1;
        end

        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        active_next = active_reg;

        if (do_start) begin
            cur_x_next  = in_sx_reg;
            cur_y_next  = in_sy_reg;
            tgt_x_next  = in_ex_reg;
            tgt_y_next  = in_ey_reg;
            dx_next     = abs_x;
            dy_next     = abs_y;
            neg_x_next  = diff_x[DW-1] || (diff_x == '0);
            neg_y_next  = diff_y[DW-1] || (diff_y == '0);
            err_next    = (abs_x > abs_y) ? $signed(ERR_W'(abs_x >> 1))
                                          : -$signed(ERR_W'(abs_y >> 1));
            color_next  = in_color_reg;
            active_next = 1'b1;
        end else if (do_step) begin
            if (done) begin
                active_next = 1'b0;
            end else begin
                err_next = err_reg - err_mx + err_my;
                if (move_x) begin
                    cur_x_next = neg_x_reg ? cur_x_reg - CB'(1) : cur_x_reg + CB'(1);
                end
                if (move_y) begin
                    cur_y_next = neg_y_reg ? cur_y_reg - CB'(1) : cur_y_reg + CB'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            tgt_x_reg    <= '0;
            tgt_y_reg    <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            neg_x_reg    <= 1'b0;
            neg_y_reg    <= 1'b0;
            err_reg      <= '0;
            color_reg    <= '0;
            active_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            tgt_x_reg    <= tgt_x_next;
            tgt_y_reg    <= tgt_y_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            neg_x_reg    <= neg_x_next;
            neg_y_reg    <= neg_y_next;
            err_reg      <= err_next;
            color_reg    <= color_next;
            active_reg   <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_op_reg    <= in_op;
            in_sx_reg    <= in_start_x;
            in_sy_reg    <= in_start_y;
            in_ex_reg    <= in_end_x;
            in_ey_reg    <= in_end_y;
            in_color_reg <= in_color;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tbls_brush_emitter.sv -----
`default_nettype none

module tbls_brush_emitter #(
    parameter int COORD_BITS = tbls_pkg::COORD_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  tbls_pkg::brush_ctl_t            ctl,
    input  wire  [COORD_BITS-1:0]           pt_x,
    input  wire  [COORD_BITS-1:0]           pt_y,
    input  wire  [tbls_pkg::COLOR_BITS-1:0] pt_color,
    output logic                            emit_free,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [COORD_BITS-1:0]           out_x,
    output logic [COORD_BITS-1:0]           out_y,
    output logic [tbls_pkg::COLOR_BITS-1:0] out_color,
    output logic                            out_last,
    output logic                            out_done
);
    import tbls_pkg::*;

    localparam int CB = COORD_BITS;

    logic                  busy_reg, busy_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CB-1:0]         snap_x_reg, snap_y_reg;
    logic [COLOR_BITS-1:0] snap_color_reg;
    logic                  snap_done_reg;

    logic                  ovalid_reg, ovalid_next;
    logic [CB-1:0]         ox_reg, oy_reg;
    logic [COLOR_BITS-1:0] ocolor_reg;
    logic                  olast_reg, odone_reg;

    logic                  slot_free, advance;
    logic signed [1:0]     off_x, off_y;
    logic [CB-1:0]         pix_x, pix_y;

    assign slot_free = !ovalid_reg || out_ready;
    assign advance   = busy_reg && slot_free;
    assign emit_free = !busy_reg || (advance && (idx_reg == BRUSH_LAST));

    assign off_x = brush_dx(idx_reg);
    assign off_y = brush_dy(idx_reg);
    assign pix_x = snap_x_reg + {{(CB-2){off_x[1]}}, off_x};
    assign pix_y = snap_y_reg + {{(CB-2){off_y[1]}}, off_y};

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (advance) begin
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg == BRUSH_LAST) begin
                busy_next = 1'b0;
            end
        end
        if (ctl.load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end

        ovalid_next = ovalid_reg;
        if (slot_free) begin
            ovalid_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            snap_x_reg     <= pt_x;
            snap_y_reg     <= pt_y;
            snap_color_reg <= pt_color;
            snap_done_reg  <= ctl.done;
        end
        if (advance) begin
            ox_reg     <= pix_x;
            oy_reg     <= pix_y;
            ocolor_reg <= snap_color_reg;
            olast_reg  <= (idx_reg == BRUSH_LAST);
            odone_reg  <= snap_done_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_color = ocolor_reg;
    assign out_last  = olast_reg;
    assign out_done  = odone_reg;

endmodule

`default_nettype wire

// ----- hdl/thick_bresenham_line_stepper_top.sv -----
// Thick Bresenham line stepper: a start transaction (s_tuser low) loads the two endpoints and
// the colour of a line and produces no output; each step transaction (s_tuser high) produces
// the nine pixels of a 3x3 brush centred on the current point, the ninth marked by m_tlast and
// all nine carrying m_tuser high when the point is the endpoint, after which the line goes idle;
// a step while idle is absorbed without output. A step that draws emits one pixel per cycle
// through the single output register while m_tready does not hold it back; the next transaction
// is taken while the last pixel of a brush still waits on m_. Pixel coordinates wrap within
// COORD_BITS bits.
`default_nettype none

module thick_bresenham_line_stepper_top #(
    parameter int COORD_BITS = tbls_pkg::COORD_BITS_DEF,
    localparam int S_DATA_W = ((4 * COORD_BITS + tbls_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * COORD_BITS + tbls_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    // start_x, start_y, end_x, end_y, pen_color from the lowest bit up, then zero padding
    input  wire  [S_DATA_W-1:0] s_tdata,
    // op: 0 starts a line, 1 steps to the next point
    input  wire                 s_tuser,
    output logic                m_tvalid,
    input  wire                 m_tready,
    // pixel_x, pixel_y, pixel_color from the lowest bit up, then zero padding
    output logic [M_DATA_W-1:0] m_tdata,
    // brush_last
    output logic                m_tlast,
    // line_done
    output logic                m_tuser
);
    import tbls_pkg::*;

    localparam int CB = COORD_BITS;

    // Fields of the incoming transaction.
    logic [CB-1:0]         start_x, start_y, end_x, end_y;
    logic [COLOR_BITS-1:0] pen_color;

    assign start_x   = s_tdata[CB-1:0];
    assign start_y   = s_tdata[2*CB-1:CB];
    assign end_x     = s_tdata[3*CB-1:2*CB];
    assign end_y     = s_tdata[4*CB-1:3*CB];
    assign pen_color = s_tdata[4*CB+COLOR_BITS-1:4*CB];

    // Between the core and the emitter: the request to snapshot a point, and the point itself.
    brush_ctl_t            ctl;
    logic                  emit_free;
    logic [CB-1:0]         pt_x, pt_y;
    logic [COLOR_BITS-1:0] pt_color;

    logic [CB-1:0]         pixel_x, pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;

    // The core holds one transaction in its input register and the line state. It retires a
    // start or an idle step at once, and a drawing step as soon as the emitter can take the
    // new point, updating the error term and position in that same cycle.
    tbls_line_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_start_x (start_x),
        .in_start_y (start_y),
        .in_end_x   (end_x),
        .in_end_y   (end_y),
        .in_color   (pen_color),
        .emit_free  (emit_free),
        .ctl        (ctl),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .pt_color   (pt_color)
    );

    // The emitter keeps a snapshot of the point and walks the brush offsets into the
    // output register, one pixel per cycle whenever the consumer allows it.
    tbls_brush_emitter #(
        .COORD_BITS (COORD_BITS)
    ) u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .pt_color   (pt_color),
        .emit_free  (emit_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (pixel_x),
        .out_y      (pixel_y),
        .out_color  (pixel_color),
        .out_last   (m_tlast),
        .out_done   (m_tuser)
    );

    assign m_tdata = M_DATA_W'({pixel_color, pixel_y, pixel_x});

endmodule

`default_nettype wire

// ----- hdl/tbls_checker.sv -----
`default_nettype none

`include "thick_bresenham_line_stepper_top_assert.svh"

module tbls_checker #(
    parameter int COORD_BITS = tbls_pkg::COORD_BITS_DEF,
    localparam int M_DATA_W = ((2 * COORD_BITS + tbls_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tready,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata,
    input wire                m_tlast,
    input wire                m_tuser
);
    import tbls_pkg::*;

    localparam int COL_LO = 2 * COORD_BITS;
    localparam int COL_HI = 2 * COORD_BITS + COLOR_BITS - 1;

    logic                  out_fire, out_stall, mid_brush;
    logic [COLOR_BITS-1:0] out_color;
    logic [M_DATA_W+1:0]   out_word;
    logic [COLOR_BITS:0]   brush_tag;

    assign out_fire  = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign mid_brush = out_fire && !m_tlast;
    assign out_color = m_tdata[COL_HI:COL_LO];
    assign out_word  = {m_tuser, m_tlast, m_tdata};
    assign brush_tag = {m_tuser, out_color};

    // A stalled pixel holds.
    `TBLS_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(out_word))

    // Pixels of one brush follow each other without a gap.
    `TBLS_ASSERT_NEXT(a_brush_burst, aclk, aresetn, mid_brush, m_tvalid)

    // Colour and endpoint flag stay the same over one brush.
    `TBLS_ASSERT_NEXT(a_brush_const, aclk, aresetn, mid_brush, $stable(brush_tag))

    // The input side is never ready while held in reset.
    `TBLS_ASSERT_SAME(a_ready_reset, aclk, 1'b1, !aresetn, !s_tready)

endmodule

bind thick_bresenham_line_stepper_top tbls_checker #(
    .COORD_BITS (COORD_BITS)
) u_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_thick_bresenham_line_stepper_top.sv -----
`default_nettype none

module tb_thick_bresenham_line_stepper_top;

    import tbls_pkg::*;

    localparam int CB        = COORD_BITS_DEF;
    localparam int S_W       = ((4 * CB + COLOR_BITS + 7) / 8) * 8;
    localparam int M_W       = ((2 * CB + COLOR_BITS + 7) / 8) * 8;
    localparam int COORD_MIN = -2047;
    localparam int COORD_MAX = 2046;

    // Useful transactions wanted from the random part (starts and steps that draw).
    localparam int ITEM_TARGET  = 450;
    // Cycles without any accepted transaction on either side before the run is abandoned.
    localparam int STALL_LIMIT  = 2000;
    // Quiet cycles after the last expected pixel, to catch anything extra from the block.
    localparam int DRAIN_CYCLES = 30;

    // Brush offsets in the order in which the block emits the nine pixels.
    localparam int BRUSH_DX [BRUSH_PIXELS] = '{0, -1, 1, -1, 0, 1, 0, 1, -1};
    localparam int BRUSH_DY [BRUSH_PIXELS] = '{0, 0, 0, 1, 1, 1, -1, -1, -1};

    typedef struct {
        logic [CB-1:0]         x;
        logic [CB-1:0]         y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  done;
    } brush_pixel_t;

    typedef enum int {RX_FLOW, RX_SPARSE, RX_CHOPPY, RX_BLOCKED} rx_mode_t;

    // Tracks the line being drawn and holds the brush pixels still owed by the block.
    class line_pixel_scoreboard;
        int           pen_x, pen_y, goal_x, goal_y;
        int           span_x, span_y, slope_err;
        bit           x_back, y_back, drawing;
        logic [COLOR_BITS-1:0] ink;
        brush_pixel_t brush_queue [$];
        int           mismatches;
        int           pixels_seen;

        function new();
            pen_x = 0; pen_y = 0; goal_x = 0; goal_y = 0;
            span_x = 0; span_y = 0; slope_err = 0;
            x_back = 0; y_back = 0; drawing = 0;
            ink = '0;
            mismatches = 0;
            pixels_seen = 0;
        endfunction

        // Notes an accepted input transaction; returns 1 when it was a start or a step that drew.
        function bit accept_command(logic op, logic [S_W-1:0] payload);
            int           sx, sy, ex, ey, e;
            bit           at_goal;
            brush_pixel_t pix;
            if (op == OP_START) begin
                sx = int'($signed(payload[CB-1:0]));
                sy = int'($signed(payload[2*CB-1:CB]));
                ex = int'($signed(payload[3*CB-1:2*CB]));
                ey = int'($signed(payload[4*CB-1:3*CB]));
                pen_x = sx; pen_y = sy; goal_x = ex; goal_y = ey;
                span_x = (ex > sx) ? ex - sx : sx - ex;
                span_y = (ey > sy) ? ey - sy : sy - ey;
                x_back = !(sx < ex);
                y_back = !(sy < ey);
                slope_err = (span_x > span_y) ? span_x / 2 : -(span_y / 2);
                ink = payload[4*CB+COLOR_BITS-1:4*CB];
                drawing = 1'b1;
                return 1'b1;
            end
            if (!drawing)
                return 1'b0;
            at_goal = (pen_x == goal_x) && (pen_y == goal_y);
            for (int k = 0; k < BRUSH_PIXELS; k++) begin
                pix.x     = CB'(pen_x + BRUSH_DX[k]);
                pix.y     = CB'(pen_y + BRUSH_DY[k]);
                pix.color = ink;
                pix.last  = (k == BRUSH_PIXELS - 1);
                pix.done  = at_goal;
                brush_queue.push_back(pix);
            end
            if (at_goal) begin
                drawing = 1'b0;
            end else begin
                e = slope_err;
                if (e > -span_x) begin
                    slope_err -= span_y;
                    pen_x += x_back ? -1 : 1;
                end
                if (e < span_y) begin
                    slope_err += span_x;
                    pen_y += y_back ? -1 : 1;
                end
            end
            return 1'b1;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("pixel %0d: %s mismatch, got %0h, expected %0h",
                     pixels_seen, what, got, want);
            mismatches++;
        endtask

        // Compares one accepted pixel with the oldest one owed.
        task check_pixel(logic [M_W-1:0] data, logic last, logic done);
            brush_pixel_t want;
            pixels_seen++;
            if (brush_queue.size() == 0) begin
                report_mismatch("unexpected pixel", data[31:0], 0);
                return;
            end
            want = brush_queue.pop_front();
            if (data[CB-1:0] !== want.x)
                report_mismatch("pixel_x", 32'(data[CB-1:0]), 32'(want.x));
            if (data[2*CB-1:CB] !== want.y)
                report_mismatch("pixel_y", 32'(data[2*CB-1:CB]), 32'(want.y));
            if (data[2*CB+COLOR_BITS-1:2*CB] !== want.color)
                report_mismatch("pixel_color", 32'(data[2*CB+COLOR_BITS-1:2*CB]),
                                32'(want.color));
            if (last !== want.last)
                report_mismatch("brush_last", 32'(last), 32'(want.last));
            if (done !== want.done)
                report_mismatch("line_done", 32'(done), 32'(want.done));
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tuser  = OP_START;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;
    logic           m_tuser;

    line_pixel_scoreboard sb = new();

    int       burst_left   = 0;
    int       useful_items = 0;
    int       idle_cycles  = 0;
    rx_mode_t stall_mode   = RX_FLOW;
    int       mode_left    = 0;

    thick_bresenham_line_stepper_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Packs the fields of a start transaction, start_x in the lowest bits.
    function automatic logic [S_W-1:0] pack_line(int sx, int sy, int ex, int ey,
                                                 logic [COLOR_BITS-1:0] col);
        logic [S_W-1:0] word;
        word = '0;
        word[CB-1:0]                   = CB'(sx);
        word[2*CB-1:CB]                = CB'(sy);
        word[3*CB-1:2*CB]              = CB'(ex);
        word[4*CB-1:3*CB]              = CB'(ey);
        word[4*CB+COLOR_BITS-1:4*CB]   = col;
        return word;
    endfunction

    // Step transactions carry random data, which the block must ignore.
    function automatic logic [S_W-1:0] noise_payload();
        return S_W'({$urandom, $urandom, $urandom});
    endfunction

    // Mostly anywhere in range, now and then right on one of the two extremes.
    function automatic int pick_coord();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
        return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Offers one transaction and waits until the block takes it. The sender works in
    // bursts: when a burst is used up it drops tvalid for a random gap and picks the length
    // of the next burst, which is now and then long enough to give a stretch with no gaps.
    task automatic send_item(logic op, logic [S_W-1:0] payload);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (sb.accept_command(op, payload))
            useful_items++;
    endtask

    // Keeps stepping the current line until it finishes or the cap is reached.
    task automatic walk_line(int cap);
        int steps;
        steps = 0;
        while (sb.drawing && steps < cap) begin
            send_item(OP_STEP, noise_payload());
            steps++;
        end
    endtask

    // Result side: checks each accepted pixel and then chooses tready for the next cycle.
    // The stall pattern switches between free flow, light and heavy random stalls, and
    // long blocked stretches, so that back-pressure lands on every pixel of a brush.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast, m_tuser);
        if (mode_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
            RX_FLOW:    m_tready <= 1'b1;
            RX_SPARSE:  m_tready <= ($urandom_range(0, 3) != 0);
            RX_CHOPPY:  m_tready <= ($urandom_range(0, 1) != 0);
            RX_BLOCKED: m_tready <= (mode_left % 12 == 0);
            default:    m_tready <= 1'b1;
        endcase
    end

    // Watchdog: a long run of cycles in which no transaction moves on either side means
    // the block has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int kind, sx, sy, ex, ey, reach, cap;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // A step straight after reset finds no line and must be absorbed silently.
        send_item(OP_STEP, noise_payload());

        // A zero-length line gives its only point flagged done; the step after it is idle.
        send_item(OP_START, pack_line(0, 0, 0, 0, 24'hFFFFFF));
        walk_line(1);
        send_item(OP_STEP, {S_W{1'b1}});

        // The longest diagonal across the whole range, abandoned after a few points by a
        // fresh start that runs back along the top edge.
        send_item(OP_START, pack_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h000000));
        walk_line(3);
        send_item(OP_START, pack_line(COORD_MAX, COORD_MIN, COORD_MAX - 3, COORD_MIN,
                                      24'hA5A5A5));
        walk_line(10);

        // The reverse diagonal, with every coordinate bit flipped relative to the first one.
        send_item(OP_START, pack_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 24'h5A5A5A));
        walk_line(2);

        // A shallow line going left and down, and a steep line along the low x edge.
        send_item(OP_START, pack_line(0, 0, -5, 2, 24'h123456));
        walk_line(10);
        send_item(OP_START, pack_line(COORD_MIN, 3, COORD_MIN + 1, -1, 24'hFEDCBA));
        walk_line(10);

        // Random lines: most are short and drawn to their end, some are longer, a few are
        // huge and cut short, and now and then a line is dropped early by the next start.
        useful_items = 0;
        while (useful_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            sx = pick_coord();
            sy = pick_coord();
            if (kind < 80) begin
                reach = 10;
            end else if (kind < 90) begin
                reach = 60;
            end else begin
                reach = 0;
            end
            if (reach != 0) begin
                ex  = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
                ey  = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
                cap = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 4) : 1000;
            end else begin
                ex  = pick_coord();
                ey  = pick_coord();
                cap = $urandom_range(0, 6);
            end
            send_item(OP_START, pack_line(sx, sy, ex, ey, COLOR_BITS'($urandom)));
            walk_line(cap);
            if ($urandom_range(0, 9) == 0)
                send_item(OP_STEP, noise_payload());
        end
        s_tvalid <= 1'b0;

        while (sb.brush_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/tbls_pkg.sv
hdl/tbls_line_core.sv
hdl/tbls_brush_emitter.sv
hdl/thick_bresenham_line_stepper_top.sv
hdl/tbls_checker.sv
tb/sv/tb_thick_bresenham_line_stepper_top.sv
